[rtl/core/buffer_frame_manager_lru_defines.svh]
// Assertion macros shared by the buffer frame manager RTL.
`ifndef BUFFER_FRAME_MANAGER_LRU_DEFINES_SVH
`define BUFFER_FRAME_MANAGER_LRU_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define BFM_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define BFM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BFM_ASSERT(lbl, ante, cons, msg)
`define BFM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/core/bfm_lru_pkg.sv]
// Types and constants of the buffer frame manager.
`timescale 1ns / 1ps

package bfm_lru_pkg;

    localparam int BFM_FRAMES_DEF = 16;
    localparam logic [15:0] PIN_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        FN_FETCH = 2'd0,
        FN_UNPIN = 2'd1,
        FN_NEW   = 2'd2,
        FN_FLUSH = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STS_OK           = 2'd0,
        STS_NO_FRAME     = 2'd1,
        STS_NOT_RESIDENT = 2'd2,
        STS_NOT_PINNED   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SEND
    } t_state;

    // One frame descriptor as held in the frame table.
    typedef struct packed {
        logic [31:0] page;
        logic [15:0] pins;
        logic        dirty;
        logic [63:0] stamp;
    } t_entry;

    typedef struct packed {
        t_status     status;
        logic [3:0]  frame_index;
        logic [31:0] page_id_out;
        logic        read_needed;
        logic        writeback_valid;
        logic [31:0] writeback_page;
        logic [3:0]  writeback_frame;
    } t_result;

endpackage

[rtl/core/buffer_frame_manager_lru.sv]
// Buffer frame manager with least-recently-used replacement, top level.
`timescale 1ns / 1ps
`include "buffer_frame_manager_lru_defines.svh"

// The block manages a pool of FRAMES page frames and answers one request per
// item with exactly one result item. A fetch hits a resident page and pins it,
// or claims the lowest never-used frame, or else the unpinned frame with the
// oldest use stamp; a dirty victim is reported for writeback and a read of the
// fetched page is requested. A new-page request takes the next id from a
// counter that starts at 1 and installs it without a read. Unpin lowers the pin
// count and can mark the frame dirty, and flush reports writeback of a dirty
// page and cleans it. Every request walks the whole frame table through a
// single read port, one frame per cycle, with one page compare and one stamp
// compare doing the work for all frames. An item passes through an accept step,
// the table walk with its registered read, a decide step that writes back the
// table, and a send step that hands the result to the output register; the
// block takes no new item until the send step is done. The output register
// holds a finished result while the next item is already being worked on; a
// result that is still not taken when the next one is ready stalls the block
// in its last step.
module buffer_frame_manager_lru
    import bfm_lru_pkg::*;
#(
    parameter int FRAMES = BFM_FRAMES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // page_id[31:0], mark_dirty[32], zero pad
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // frame_index[3:0], page_id_out[35:4], read_needed[36], writeback_valid[37],
    // writeback_page[69:38], writeback_frame[73:70], zero pad
    output logic [79:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    // Frame index width and a walk counter that can also hold FRAMES itself.
    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);

    // Frame indices are reported in four bits; wider pools report the low bits.
    function automatic logic [3:0] to_fi(input logic [IW-1:0] idx);
        logic [IW+3:0] w;
        w = {4'b0, idx};
        return w[3:0];
    endfunction

    // Control registers.
    t_state            r_state, n_state;
    logic              r_rd_vld, n_rd_vld;
    logic [FRAMES-1:0] r_unused, n_unused;
    logic [63:0]       r_use_clk, n_use_clk;
    logic [31:0]       r_next_page, n_next_page;
    logic              r_m_valid, n_m_valid;

    // Request and walk bookkeeping.
    t_func             r_func, n_func;
    logic [31:0]       r_pid, n_pid;
    logic              r_md, n_md;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [IW-1:0]     r_rd_idx, n_rd_idx;
    logic              r_hit, n_hit;
    logic [IW-1:0]     r_hit_idx, n_hit_idx;
    t_entry            r_hit_ent, n_hit_ent;
    logic              r_free_vld, n_free_vld;
    logic [IW-1:0]     r_free_idx, n_free_idx;
    logic              r_best_vld, n_best_vld;
    logic [IW-1:0]     r_best_idx, n_best_idx;
    logic [31:0]       r_best_page, n_best_page;
    logic              r_best_dirty, n_best_dirty;
    logic [63:0]       r_oldest, n_oldest;
    t_result           r_res, n_res;
    t_result           r_m_res, n_m_res;

    // Frame table: one write port, one registered read port.
    t_entry            r_mem [FRAMES];
    t_entry            r_rd_data;
    logic [IW-1:0]     rd_addr;
    logic              mem_we;
    logic [IW-1:0]     mem_wa;
    t_entry            mem_wd;

    // Decision helpers.
    logic              claim_ok;
    logic [IW-1:0]     claim_idx;
    logic              victim_wb;
    logic [63:0]       stamp_new;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_vld    <= 1'b0;
            r_unused    <= '1;
            r_use_clk   <= '0;
            r_next_page <= 32'd1;
            r_m_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_vld    <= n_rd_vld;
            r_unused    <= n_unused;
            r_use_clk   <= n_use_clk;
            r_next_page <= n_next_page;
            r_m_valid   <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_pid        <= n_pid;
        r_md         <= n_md;
        r_cnt        <= n_cnt;
        r_rd_idx     <= n_rd_idx;
        r_hit        <= n_hit;
        r_hit_idx    <= n_hit_idx;
        r_hit_ent    <= n_hit_ent;
        r_free_vld   <= n_free_vld;
        r_free_idx   <= n_free_idx;
        r_best_vld   <= n_best_vld;
        r_best_idx   <= n_best_idx;
        r_best_page  <= n_best_page;
        r_best_dirty <= n_best_dirty;
        r_oldest     <= n_oldest;
        r_res        <= n_res;
        r_m_res      <= n_m_res;
    end

    // A claim takes the lowest never-used frame first, else the LRU victim.
    assign claim_ok  = r_free_vld || r_best_vld;
    assign claim_idx = r_free_vld ? r_free_idx : r_best_idx;
    assign victim_wb = !r_free_vld && r_best_vld && r_best_dirty;
    assign stamp_new = r_use_clk + 64'd1;

    always_comb begin
        n_state      = r_state;
        n_rd_vld     = 1'b0;
        n_unused     = r_unused;
        n_use_clk    = r_use_clk;
        n_next_page  = r_next_page;
        n_m_valid    = r_m_valid;
        n_func       = r_func;
        n_pid        = r_pid;
        n_md         = r_md;
        n_cnt        = r_cnt;
        n_rd_idx     = r_cnt[IW-1:0];
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_hit_ent    = r_hit_ent;
        n_free_vld   = r_free_vld;
        n_free_idx   = r_free_idx;
        n_best_vld   = r_best_vld;
        n_best_idx   = r_best_idx;
        n_best_page  = r_best_page;
        n_best_dirty = r_best_dirty;
        n_oldest     = r_oldest;
        n_res        = r_res;
        n_m_res      = r_m_res;
        mem_we       = 1'b0;
        mem_wa       = r_hit_idx;
        mem_wd       = r_hit_ent;
        rd_addr      = (r_cnt < CW'(FRAMES)) ? r_cnt[IW-1:0] : '0;

        // The output register empties when the consumer takes the result.
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_func     = t_func'(s_axis_tuser);
                    n_pid      = s_axis_tdata[31:0];
                    n_md       = s_axis_tdata[32];
                    n_cnt      = '0;
                    n_hit      = 1'b0;
                    n_free_vld = 1'b0;
                    n_best_vld = 1'b0;
                    n_oldest   = '1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt != CW'(FRAMES)) begin
                    n_rd_vld = 1'b1;
                    n_cnt    = r_cnt + CW'(1);
                end else begin
                    n_state = S_DECIDE;
                end
                // Examine the frame read in the previous cycle.
                if (r_rd_vld) begin
                    if (r_unused[r_rd_idx]) begin
                        if (!r_free_vld) begin
                            n_free_vld = 1'b1;
                            n_free_idx = r_rd_idx;
                        end
                    end else begin
                        if (!r_hit && r_rd_data.page == r_pid) begin
                            n_hit     = 1'b1;
                            n_hit_idx = r_rd_idx;
                            n_hit_ent = r_rd_data;
                        end
                        if (r_rd_data.pins == 16'd0 && r_rd_data.stamp < r_oldest) begin
                            n_oldest     = r_rd_data.stamp;
                            n_best_vld   = 1'b1;
                            n_best_idx   = r_rd_idx;
                            n_best_page  = r_rd_data.page;
                            n_best_dirty = r_rd_data.dirty;
                        end
                    end
                end
            end
            S_DECIDE: begin
                n_res                 = '0;
                n_res.status          = STS_OK;
                n_res.page_id_out     = r_pid;
                n_state               = S_SEND;
                case (r_func)
                    FN_FETCH: begin
                        if (r_hit) begin
                            mem_we       = 1'b1;
                            mem_wa       = r_hit_idx;
                            mem_wd       = r_hit_ent;
                            mem_wd.pins  = (r_hit_ent.pins == PIN_MAX) ? PIN_MAX
                                                                      : r_hit_ent.pins + 16'd1;
                            mem_wd.stamp = stamp_new;
                            n_use_clk    = stamp_new;
                            n_res.frame_index = to_fi(r_hit_idx);
                        end else if (claim_ok) begin
                            mem_we       = 1'b1;
                            mem_wa       = claim_idx;
                            mem_wd.page  = r_pid;
                            mem_wd.pins  = 16'd1;
                            mem_wd.dirty = 1'b0;
                            mem_wd.stamp = stamp_new;
                            n_use_clk    = stamp_new;
                            if (r_free_vld) begin
                                n_unused[r_free_idx] = 1'b0;
                            end
                            n_res.frame_index     = to_fi(claim_idx);
                            n_res.read_needed     = 1'b1;
                            if (victim_wb) begin
                                n_res.writeback_valid = 1'b1;
                                n_res.writeback_page  = r_best_page;
                                n_res.writeback_frame = to_fi(r_best_idx);
                            end
                        end else begin
                            n_res.status = STS_NO_FRAME;
                        end
                    end
                    FN_UNPIN: begin
                        if (!r_hit) begin
                            n_res.status = STS_NOT_RESIDENT;
                        end else begin
                            n_res.frame_index = to_fi(r_hit_idx);
                            if (r_hit_ent.pins == 16'd0) begin
                                n_res.status = STS_NOT_PINNED;
                            end else begin
                                mem_we       = 1'b1;
                                mem_wa       = r_hit_idx;
                                mem_wd       = r_hit_ent;
                                mem_wd.pins  = r_hit_ent.pins - 16'd1;
                                mem_wd.dirty = r_hit_ent.dirty | r_md;
                            end
                        end
                    end
                    FN_NEW: begin
                        // The id is consumed even when no frame can take it.
                        n_next_page       = r_next_page + 32'd1;
                        n_res.page_id_out = r_next_page;
                        if (r_next_page == 32'd0) begin
                            n_res.status = STS_NO_FRAME;
                        end else if (claim_ok) begin
                            mem_we       = 1'b1;
                            mem_wa       = claim_idx;
                            mem_wd.page  = r_next_page;
                            mem_wd.pins  = 16'd1;
                            mem_wd.dirty = 1'b0;
                            mem_wd.stamp = stamp_new;
                            n_use_clk    = stamp_new;
                            if (r_free_vld) begin
                                n_unused[r_free_idx] = 1'b0;
                            end
                            n_res.frame_index = to_fi(claim_idx);
                            if (victim_wb) begin
                                n_res.writeback_valid = 1'b1;
                                n_res.writeback_page  = r_best_page;
                                n_res.writeback_frame = to_fi(r_best_idx);
                            end
                        end else begin
                            n_res.status = STS_NO_FRAME;
                        end
                    end
                    FN_FLUSH: begin
                        if (!r_hit) begin
                            n_res.status = STS_NOT_RESIDENT;
                        end else begin
                            n_res.frame_index = to_fi(r_hit_idx);
                            if (r_hit_ent.dirty) begin
                                mem_we                = 1'b1;
                                mem_wa                = r_hit_idx;
                                mem_wd                = r_hit_ent;
                                mem_wd.dirty          = 1'b0;
                                n_res.writeback_valid = 1'b1;
                                n_res.writeback_page  = r_hit_ent.page;
                                n_res.writeback_frame = to_fi(r_hit_idx);
                            end
                        end
                    end
                    default: begin
                        n_res.status = STS_NOT_RESIDENT;
                    end
                endcase
            end
            S_SEND: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_res   = r_res;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_res.status;
    assign m_axis_tdata  = {6'b0,
                            r_m_res.writeback_frame,
                            r_m_res.writeback_page,
                            r_m_res.writeback_valid,
                            r_m_res.read_needed,
                            r_m_res.page_id_out,
                            r_m_res.frame_index};

    // A request occupies the block for the whole table walk.
    `BFM_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready right after accept")
    // Frames are only ever taken from the never-used pool, never returned.
    `BFM_ASSERT(a_unused_shrinks, $past(i_rst_n), $countones(r_unused) <= $past($countones(r_unused)), "unused frame reappeared")
    // Writeback and read requests only come with a successful status.
    `BFM_ASSERT(a_wb_only_ok, m_axis_tvalid && (m_axis_tdata[37] || m_axis_tdata[36]), m_axis_tuser == STS_OK, "writeback or read with error status")

endmodule
